### design/cakv_pkg.sv
// ----------------------------------------------------------------------------
// cakv_pkg
// Shared types, constants and the exponent table of the causal attention
// block with its key/value cache.
// ----------------------------------------------------------------------------
package cakv_pkg;

    // Datapath widths that follow from the fixed field widths.
    localparam int DVD_W     = 41;     // divider dividend and quotient
    localparam int DVS_W     = 25;     // divider divisor (weight sum)
    localparam int ACC_W     = 41;     // dot product and weighted sum accumulator
    localparam int MUL_A_W   = 33;     // shared multiplier, first operand
    localparam int MUL_B_W   = 18;     // shared multiplier, second operand
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int LOG2E_Q16 = 94548;  // log2(e) in Q.16

    // Configuration register indexes.
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t REG_HEAD_DIM  = 2'd0;
    localparam cfg_idx_t REG_NUM_Q     = 2'd1;
    localparam cfg_idx_t REG_NUM_KV    = 2'd2;
    localparam cfg_idx_t REG_SCALE     = 2'd3;

    // Request and response of the shared divider.
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    // Table of 2^(-k/16) in Q.16 for k = 0..16.
    function automatic logic [16:0] exp2_tab(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

### design/cakv_ram.sv
// ----------------------------------------------------------------------------
// cakv_ram
// Generic simple dual-port RAM: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cakv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### design/cakv_mul.sv
// ----------------------------------------------------------------------------
// cakv_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module cakv_mul (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [cakv_pkg::MUL_A_W-1:0] a,
    input  logic signed [cakv_pkg::MUL_B_W-1:0] b,
    output logic signed [cakv_pkg::PROD_W-1:0]  prod_reg
);

    import cakv_pkg::*;

    // The product is held until the next enabled cycle.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

endmodule

### design/cakv_div.sv
// ----------------------------------------------------------------------------
// cakv_div
// Iterative unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cakv_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  cakv_pkg::div_req_t  req,
    output cakv_pkg::div_rsp_t  rsp
);

    import cakv_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic             fits;

    // Trial subtraction of one step.
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### design/causal_attention_kv_cache.sv
// ----------------------------------------------------------------------------
// causal_attention_kv_cache
// Grouped-query causal attention over a key/value cache in Q4.11.
//
// The s_ channel carries cache writes (tuser = 0) and query elements
// (tuser = 1), taken only while the sequencer is idle. Out-of-range
// items are dropped. The query element of the last used dimension
// starts the attention for that head at its position p; s_tready stays
// low until all of its results have been delivered on the m_ channel,
// one per dimension, with tlast on the last one. All multiplies run on
// one shared multiplier and all divisions on one shared divider under
// the sequencer, with one RAM read per step. Two divisions map the query
// head to its kv head; each position up to p then gets a dot product, a
// scaled score and a softmax weight, and each dimension a weighted sum,
// a rounded division by the weight sum and one output. A stalled
// receiver holds the sequencer with the result in the output register.
// Reset restores the register defaults and clears control state; the
// cache and buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module causal_attention_kv_cache #(
    parameter int MAX_POSITIONS = 256,
    parameter int MAX_KV_HEADS  = 4,
    parameter int MAX_HEAD_DIM  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // position[7:0], head[11:8], dim[17:12], first_elem[33:18],
    // second_elem[49:34], zero fill [55:50]
    input  logic [55:0] s_tdata,
    // req_type[0]
    input  logic [0:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_head[3:0], out_dim[9:4], out_value[25:10], zero fill [31:26]
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    import cakv_pkg::*;

    localparam int KV_DEPTH = MAX_POSITIONS * MAX_KV_HEADS * MAX_HEAD_DIM;
    localparam int KV_AW    = (KV_DEPTH > 1) ? $clog2(KV_DEPTH) : 1;
    localparam int HD_LIM   = (MAX_HEAD_DIM < 64) ? MAX_HEAD_DIM : 64;
    localparam int QB_AW    = (HD_LIM > 1) ? $clog2(HD_LIM) : 1;
    localparam int SC_DEPTH = (MAX_POSITIONS < 256) ? MAX_POSITIONS : 256;
    localparam int SC_AW    = (SC_DEPTH > 1) ? $clog2(SC_DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_GRP, ST_GRP_W, ST_KVH, ST_KVH_W,
        ST_D_RD, ST_D_MUL, ST_D_ACC, ST_S_LO, ST_S_HI, ST_S_FIN,
        ST_W_RD, ST_W_MUL, ST_W_INT, ST_W_FIN,
        ST_O_RD, ST_O_MUL, ST_O_ACC, ST_O_DIV, ST_O_DIVW, ST_O_OUT
    } state_t;

    // Flat cache address of a position, kv head and dimension.
    function automatic logic [KV_AW-1:0] kv_addr(input logic [7:0] p,
                                                 input logic [3:0] h,
                                                 input logic [5:0] dd);
        int a;
        a = (int'(p) * MAX_KV_HEADS + int'(h)) * MAX_HEAD_DIM + int'(dd);
        return KV_AW'(a);
    endfunction

    // Configuration registers.
    logic [6:0]  hd_reg;
    logic [4:0]  nq_reg;
    logic [2:0]  nkv_reg;
    logic [15:0] scale_reg;

    // Sequencer registers.
    state_t                  state_reg;
    logic [7:0]              pos_reg;
    logic [3:0]              head_reg;
    logic [4:0]              group_reg;
    logic [3:0]              kvh_reg;
    logic [7:0]              j_reg;
    logic [5:0]              d_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [37:0]             lo_reg;
    logic signed [31:0]      mx_reg;
    logic [16:0]             ta_reg;
    logic [4:0]              ip_reg;
    logic                    ipz_reg;
    logic [DVS_W-1:0]        wsum_reg;
    logic                    neg_reg;

    // Output register.
    logic        mvalid_reg;
    logic [3:0]  ohead_reg;
    logic [5:0]  odim_reg;
    logic [15:0] oval_reg;
    logic        olast_reg;

    // Input fields.
    logic              s_req;
    logic [7:0]        s_pos;
    logic [3:0]        s_head;
    logic [5:0]        s_dim;
    logic [15:0]       s_first;
    logic [15:0]       s_second;

    assign s_req    = s_tuser[0];
    assign s_pos    = s_tdata[7:0];
    assign s_head   = s_tdata[11:8];
    assign s_dim    = s_tdata[17:12];
    assign s_first  = s_tdata[33:18];
    assign s_second = s_tdata[49:34];

    // Effective register values after clamping.
    logic [6:0] hd_eff;
    logic [4:0] nq_eff;
    logic [2:0] nkv_eff;

    always_comb begin
        if (hd_reg == 7'd0) begin
            hd_eff = 7'd1;
        end else if (int'(hd_reg) > HD_LIM) begin
            hd_eff = 7'(HD_LIM);
        end else begin
            hd_eff = hd_reg;
        end
        if (nq_reg == 5'd0) begin
            nq_eff = 5'd1;
        end else if (nq_reg > 5'd16) begin
            nq_eff = 5'd16;
        end else begin
            nq_eff = nq_reg;
        end
        if (nkv_reg == 3'd0) begin
            nkv_eff = 3'd1;
        end else if (int'(nkv_reg) > MAX_KV_HEADS) begin
            nkv_eff = 3'(MAX_KV_HEADS);
        end else begin
            nkv_eff = nkv_reg;
        end
    end

    // Input decode: cache write, query element and query start.
    logic in_acc, in_ok, cache_we, q_we, q_last, d_last, j_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_ok    = (int'(s_pos) < MAX_POSITIONS) && ({1'b0, s_dim} < hd_eff);
    assign cache_we = in_acc && !s_req && in_ok && (5'(s_head) < 5'(nkv_eff));
    assign q_we     = in_acc && s_req && in_ok && (5'(s_head) < nq_eff);
    assign q_last   = q_we && ({1'b0, s_dim} == hd_eff - 7'd1);
    assign d_last   = ({1'b0, d_reg} == hd_eff - 7'd1);
    assign j_last   = (j_reg == pos_reg);

    // Memories.
    logic [KV_AW-1:0] kv_raddr, kv_waddr;
    logic [15:0]      k_rd, v_rd, q_rd;
    logic [31:0]      sc_rd, sc_wdata;
    logic             sc_we;

    assign kv_waddr = kv_addr(s_pos, s_head, s_dim);
    assign kv_raddr = kv_addr(j_reg, kvh_reg, d_reg);

    cakv_ram #(.WIDTH(16), .DEPTH(KV_DEPTH)) u_key_ram (
        .aclk    (aclk),
        .wr_en   (cache_we),
        .wr_addr (kv_waddr),
        .wr_data (s_first),
        .rd_addr (kv_raddr),
        .rd_data (k_rd)
    );

    cakv_ram #(.WIDTH(16), .DEPTH(KV_DEPTH)) u_value_ram (
        .aclk    (aclk),
        .wr_en   (cache_we),
        .wr_addr (kv_waddr),
        .wr_data (s_second),
        .rd_addr (kv_raddr),
        .rd_data (v_rd)
    );

    cakv_ram #(.WIDTH(16), .DEPTH(HD_LIM)) u_query_ram (
        .aclk    (aclk),
        .wr_en   (q_we),
        .wr_addr (s_dim[QB_AW-1:0]),
        .wr_data (s_first),
        .rd_addr (d_reg[QB_AW-1:0]),
        .rd_data (q_rd)
    );

    cakv_ram #(.WIDTH(32), .DEPTH(SC_DEPTH)) u_score_ram (
        .aclk    (aclk),
        .wr_en   (sc_we),
        .wr_addr (j_reg[SC_AW-1:0]),
        .wr_data (sc_wdata),
        .rd_addr (j_reg[SC_AW-1:0]),
        .rd_data (sc_rd)
    );

    // Shared multiplier.
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    cakv_mul u_mul (
        .aclk     (aclk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    // Shared divider.
    div_req_t div_req;
    div_rsp_t div_rsp;

    cakv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Score, weight and rounding arithmetic around the multiplier.
    logic signed [32:0]  dd_full;
    logic [48:0]         t_full;
    logic [31:0]         t_q16;
    logic [16:0]         tab_a, tab_b;
    logic [16:0]         corr, w_int, w_val;
    logic signed [63:0]  sc_sum;
    logic signed [31:0]  sc_s;
    logic [ACC_W-1:0]    mag;
    logic [DVD_W-1:0]    dividend;
    logic [15:0]         sat_val;
    logic [DVD_W-1:0]    quo;

    always_comb begin
        dd_full  = {mx_reg[31], mx_reg} - {sc_rd[31], sc_rd};
        t_full   = {1'b0, prod[47:0]} + 49'd32768;
        t_q16    = t_full[47:16];
        tab_a    = exp2_tab({1'b0, t_q16[15:12]});
        tab_b    = exp2_tab({1'b0, t_q16[15:12]} + 5'd1);
        corr     = 17'((prod[29:0] + 30'd2048) >> 12);
        w_int    = ta_reg - corr;
        w_val    = ipz_reg ? 17'd0 : (w_int >> ip_reg);
        sc_sum   = (64'(prod) <<< 21) + $signed({26'b0, lo_reg}) + 64'sd2097152;
        sc_s     = sc_sum[53:22];
        mag      = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        dividend = DVD_W'(mag) + DVD_W'(wsum_reg[DVS_W-1:1]);
        quo      = div_rsp.quotient;
        if (neg_reg) begin
            sat_val = (quo > DVD_W'(32768)) ? 16'h8000 : 16'(~quo[15:0] + 16'd1);
        end else begin
            sat_val = (quo > DVD_W'(32767)) ? 16'h7FFF : quo[15:0];
        end
    end

    // Operand selection for the multiplier, score RAM write and divider.
    always_comb begin
        mul_en   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        sc_we    = 1'b0;
        sc_wdata = '0;
        div_req  = '0;
        case (state_reg)
            ST_D_MUL: begin
                mul_en = 1'b1;
                mul_a  = {{17{q_rd[15]}}, q_rd};
                mul_b  = {{2{k_rd[15]}}, k_rd};
            end
            ST_S_LO: begin
                mul_en = 1'b1;
                mul_a  = {12'b0, acc_reg[20:0]};
                mul_b  = {2'b0, scale_reg};
            end
            ST_S_HI: begin
                mul_en = 1'b1;
                mul_a  = {{13{acc_reg[40]}}, acc_reg[40:21]};
                mul_b  = {2'b0, scale_reg};
            end
            ST_S_FIN: begin
                sc_we    = 1'b1;
                sc_wdata = sc_s;
            end
            ST_W_MUL: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, dd_full[31:0]};
                mul_b  = MUL_B_W'(LOG2E_Q16);
            end
            ST_W_INT: begin
                mul_en = 1'b1;
                mul_a  = {16'b0, tab_a - tab_b};
                mul_b  = {6'b0, t_q16[11:0]};
            end
            ST_W_FIN: begin
                sc_we    = 1'b1;
                sc_wdata = {15'b0, w_val};
            end
            ST_O_MUL: begin
                mul_en = 1'b1;
                mul_a  = {16'b0, sc_rd[16:0]};
                mul_b  = {{2{v_rd[15]}}, v_rd};
            end
            ST_GRP: begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(nq_eff);
                div_req.divisor  = DVS_W'(nkv_eff);
            end
            ST_KVH: begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(head_reg);
                div_req.divisor  = DVS_W'(group_reg);
            end
            ST_O_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = dividend;
                div_req.divisor  = wsum_reg;
            end
            default: begin
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hd_reg    <= 7'd64;
            nq_reg    <= 5'd8;
            nkv_reg   <= 3'd2;
            scale_reg <= 16'd8192;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HEAD_DIM: hd_reg    <= cfg_wdata[6:0];
                REG_NUM_Q:    nq_reg    <= cfg_wdata[4:0];
                REG_NUM_KV:   nkv_reg   <= cfg_wdata[2:0];
                REG_SCALE:    scale_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_last) begin
                        head_reg  <= s_head;
                        pos_reg   <= s_pos;
                        state_reg <= ST_GRP;
                    end
                end
                ST_GRP: state_reg <= ST_GRP_W;
                ST_GRP_W: begin
                    if (div_rsp.done) begin
                        group_reg <= (div_rsp.quotient[4:0] == 5'd0) ? 5'd1
                                                                    : div_rsp.quotient[4:0];
                        state_reg <= ST_KVH;
                    end
                end
                ST_KVH: state_reg <= ST_KVH_W;
                ST_KVH_W: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quotient > DVD_W'(nkv_eff - 3'd1)) begin
                            kvh_reg <= 4'(nkv_eff - 3'd1);
                        end else begin
                            kvh_reg <= div_rsp.quotient[3:0];
                        end
                        j_reg     <= '0;
                        d_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_D_RD;
                    end
                end
                // Dot product of the query with the key of position j.
                ST_D_RD:  state_reg <= ST_D_MUL;
                ST_D_MUL: state_reg <= ST_D_ACC;
                ST_D_ACC: begin
                    acc_reg <= acc_reg + prod[ACC_W-1:0];
                    if (d_last) begin
                        d_reg     <= '0;
                        state_reg <= ST_S_LO;
                    end else begin
                        d_reg     <= d_reg + 6'd1;
                        state_reg <= ST_D_RD;
                    end
                end
                // Scaled score, then running maximum.
                ST_S_LO: state_reg <= ST_S_HI;
                ST_S_HI: begin
                    lo_reg    <= prod[37:0];
                    state_reg <= ST_S_FIN;
                end
                ST_S_FIN: begin
                    if (j_reg == 8'd0 || sc_s > mx_reg) begin
                        mx_reg <= sc_s;
                    end
                    acc_reg <= '0;
                    if (j_last) begin
                        j_reg     <= '0;
                        wsum_reg  <= '0;
                        state_reg <= ST_W_RD;
                    end else begin
                        j_reg     <= j_reg + 8'd1;
                        state_reg <= ST_D_RD;
                    end
                end
                // Softmax weight of position j from the tabled exp.
                ST_W_RD:  state_reg <= ST_W_MUL;
                ST_W_MUL: state_reg <= ST_W_INT;
                ST_W_INT: begin
                    ta_reg    <= tab_a;
                    ipz_reg   <= (t_q16[31:16] >= 16'd17);
                    ip_reg    <= t_q16[20:16];
                    state_reg <= ST_W_FIN;
                end
                ST_W_FIN: begin
                    wsum_reg <= wsum_reg + DVS_W'(w_val);
                    if (j_last) begin
                        j_reg     <= '0;
                        d_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_O_RD;
                    end else begin
                        j_reg     <= j_reg + 8'd1;
                        state_reg <= ST_W_RD;
                    end
                end
                // Weighted sum of values for dimension d.
                ST_O_RD:  state_reg <= ST_O_MUL;
                ST_O_MUL: state_reg <= ST_O_ACC;
                ST_O_ACC: begin
                    acc_reg <= acc_reg + prod[ACC_W-1:0];
                    if (j_last) begin
                        state_reg <= ST_O_DIV;
                    end else begin
                        j_reg     <= j_reg + 8'd1;
                        state_reg <= ST_O_RD;
                    end
                end
                ST_O_DIV: begin
                    neg_reg   <= acc_reg[ACC_W-1];
                    state_reg <= ST_O_DIVW;
                end
                ST_O_DIVW: begin
                    if (div_rsp.done) begin
                        mvalid_reg <= 1'b1;
                        ohead_reg  <= head_reg;
                        odim_reg   <= d_reg;
                        oval_reg   <= sat_val;
                        olast_reg  <= d_last;
                        state_reg  <= ST_O_OUT;
                    end
                end
                // Hold the result until the receiver takes the transaction.
                ST_O_OUT: begin
                    if (m_tready) begin
                        mvalid_reg <= 1'b0;
                        j_reg      <= '0;
                        acc_reg    <= '0;
                        if (d_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            d_reg     <= d_reg + 6'd1;
                            state_reg <= ST_O_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {6'b0, oval_reg, odim_reg, ohead_reg};
    assign m_tlast  = olast_reg;

    // The block never takes input while a result is pending.
    assert property (@(posedge aclk) disable iff (!aresetn) s_tready |-> !m_tvalid)
        else $error("input accepted while a result is pending");

    // The last result of a query returns the block to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
                     (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not idle after last result");

    // The divider is only started when it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
                     div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

endmodule

### dv/tb_causal_attention_kv_cache.sv
// ----------------------------------------------------------------------------
// tb_causal_attention_kv_cache
// Self-checking testbench for the grouped-query causal attention block.
//
// Cache writes and query elements are driven on the s_ stream with random
// gaps. Every accepted transaction updates a local model of the cache and
// the query buffer. When a query completes, that model computes the
// attention output for every dimension. The m_ stream is stalled at random,
// and once for a long stretch. Each result is compared field by field with
// the oldest pending expectation. A default-register query and a directed
// table open the run. Random phases follow, each under a new register
// setting that includes the clamped extremes and uneven head grouping.
// ----------------------------------------------------------------------------
module tb_causal_attention_kv_cache;
    import cakv_pkg::*;

    localparam int  MAX_POS      = 256;
    localparam int  MAX_KVH      = 4;
    localparam int  MAX_DIM      = 64;
    localparam int  IDLE_LIMIT   = 200000;
    localparam int  LONG_HOLD    = 3000;
    localparam int  SETTLE       = 40;
    localparam bit  REQ_KV       = 1'b0;
    localparam bit  REQ_QUERY    = 1'b1;

    // Table of 2^(-k/16) in Q.16 used by the softmax weight.
    localparam longint POW2_FRAC [0:16] = '{
        65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
        46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
    };

    typedef struct {
        bit               req;
        bit [7:0]         pos;
        bit [3:0]         head;
        bit [5:0]         dim;
        bit signed [15:0] e1;
        bit signed [15:0] e2;
    } attn_item_t;

    typedef struct {
        bit [3:0]         head;
        bit [5:0]         dim;
        bit signed [15:0] value;
        bit               last;
    } attn_out_t;

    // Directed row: an item plus an optional hand-computed output value.
    typedef struct {
        attn_item_t       item;
        bit               typed;
        bit signed [15:0] value;
    } directed_row_t;

    typedef struct {
        int hd;
        int nq;
        int nkv;
        int scale;
        int max_pos;
        int budget;
    } phase_cfg_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    causal_attention_kv_cache DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Model state: registers, cache, query buffer and written flags.
    int unsigned      reg_hd, reg_nq, reg_nkv, reg_scale;
    logic signed [15:0] key_mem [0:MAX_POS*MAX_KVH*MAX_DIM-1];
    logic signed [15:0] val_mem [0:MAX_POS*MAX_KVH*MAX_DIM-1];
    logic signed [15:0] query_vec [0:MAX_DIM-1];
    bit               kv_written [0:MAX_POS*MAX_KVH*MAX_DIM-1];
    bit               q_written [0:MAX_DIM-1];

    attn_out_t        attn_expect_q [$];
    int               error_count;
    int               items_sent;
    int               phase_items;
    int               queries_done;
    int               results_seen;
    bit               hold_request;
    bit               tx_quiet;
    bit               rx_quiet;

    // Clock.
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic int eff_hd();
        if (reg_hd < 1) return 1;
        return (reg_hd > MAX_DIM) ? MAX_DIM : reg_hd;
    endfunction

    function automatic int eff_nq();
        if (reg_nq < 1) return 1;
        return (reg_nq > 16) ? 16 : reg_nq;
    endfunction

    function automatic int eff_nkv();
        if (reg_nkv < 1) return 1;
        return (reg_nkv > MAX_KVH) ? MAX_KVH : reg_nkv;
    endfunction

    // Query head to kv head, with the group size floored at one.
    function automatic int kv_head_of(int qh);
        int grp;
        int kvh;
        grp = eff_nq() / eff_nkv();
        if (grp < 1) grp = 1;
        kvh = qh / grp;
        if (kvh > eff_nkv() - 1) kvh = eff_nkv() - 1;
        return kvh;
    endfunction

    function automatic int cache_index(int p, int h, int d);
        return (p * MAX_KVH + h) * MAX_DIM + d;
    endfunction

    // Softmax weight 2^(-gap*log2e) in Q.16 from the interpolated table.
    function automatic longint softmax_weight(longint gap);
        longint t, ip, fr, a, b, v;
        t  = (gap * 94548 + 32768) >>> 16;
        ip = t >>> 16;
        fr = t & 16'hFFFF;
        a  = POW2_FRAC[fr >>> 12];
        b  = POW2_FRAC[(fr >>> 12) + 1];
        v  = a - (((a - b) * (fr & 12'hFFF) + 2048) >>> 12);
        if (ip >= 17) return 0;
        return v >>> ip;
    endfunction

    // Applies one accepted transaction to the model and queues its outputs.
    task automatic predict_attention(input attn_item_t it);
        int        hd, kvh, ix;
        longint    dot, mx, wsum, acc, half, q;
        longint    score [0:MAX_POS-1];
        attn_out_t r;
        hd = eff_hd();
        if (it.dim >= hd) return;
        if (it.req == REQ_KV) begin
            if (it.head >= eff_nkv()) return;
            ix = cache_index(it.pos, it.head, it.dim);
            key_mem[ix]    = it.e1;
            val_mem[ix]    = it.e2;
            kv_written[ix] = 1'b1;
            return;
        end
        if (it.head >= eff_nq()) return;
        query_vec[it.dim] = it.e1;
        q_written[it.dim] = 1'b1;
        if (it.dim != hd - 1) return;

        kvh = kv_head_of(it.head);
        // Scaled dot products and their maximum.
        mx = -(64'sd1 <<< 40);
        for (int j = 0; j <= it.pos; j++) begin
            dot = 0;
            for (int d = 0; d < hd; d++)
                dot += longint'(query_vec[d]) * longint'(key_mem[cache_index(j, kvh, d)]);
            score[j] = (dot * longint'(reg_scale) + (64'sd1 <<< 21)) >>> 22;
            if (score[j] > mx) mx = score[j];
        end
        // Weights replace the scores.
        wsum = 0;
        for (int j = 0; j <= it.pos; j++) begin
            score[j] = softmax_weight(mx - score[j]);
            wsum += score[j];
        end
        // Weighted average per dimension, rounded away from zero and saturated.
        half = wsum / 2;
        for (int d = 0; d < hd; d++) begin
            acc = 0;
            for (int j = 0; j <= it.pos; j++)
                acc += score[j] * longint'(val_mem[cache_index(j, kvh, d)]);
            if (acc >= 0) q = (acc + half) / wsum;
            else          q = -((-acc + half) / wsum);
            if (q > 32767)  q = 32767;
            if (q < -32768) q = -32768;
            r.head  = it.head;
            r.dim   = d[5:0];
            r.value = q[15:0];
            r.last  = (d == hd - 1);
            attn_expect_q.insert(attn_expect_q.size(), r);
        end
        queries_done++;
    endtask

    // Drives one transaction after a random gap and waits for acceptance.
    task automatic send_item(input attn_item_t it);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 49) == 0) tx_quiet = ~tx_quiet;
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.req;
        s_tdata  <= {6'd0, it.e2, it.e1, it.dim, it.head, it.pos};
        do @(posedge aclk); while (!s_tready);
        predict_attention(it);
        items_sent++;
        phase_items++;
    endtask

    task automatic drop_valid();
        @(negedge aclk) s_tvalid <= 1'b0;
    endtask

    function automatic bit signed [15:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return 16'($signed($urandom_range(0, 4095)) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    // An item that never starts an attention pass.
    task automatic send_noise();
        attn_item_t it;
        it.req  = 1'($urandom_range(0, 1));
        it.pos  = 8'($urandom_range(0, 255));
        it.head = 4'($urandom_range(0, 15));
        it.dim  = 6'($urandom_range(0, 63));
        it.e1   = rand_elem();
        it.e2   = rand_elem();
        if (it.req == REQ_QUERY && it.head < eff_nq() && it.dim == eff_hd() - 1) begin
            if (eff_hd() < MAX_DIM)  it.dim  = 6'($urandom_range(eff_hd(), 63));
            else if (eff_nq() < 16)  it.head = 4'($urandom_range(eff_nq(), 15));
            else                     it.req  = REQ_KV;
        end
        send_item(it);
    endtask

    // A well-formed query: fill the cache it needs, then send its elements.
    task automatic attend(input int qh, input int p, input bit stale);
        attn_item_t it;
        int         hd, kvh;
        bit         all_seen;
        hd  = eff_hd();
        kvh = kv_head_of(qh);
        for (int j = 0; j <= p; j++) begin
            for (int d = 0; d < hd; d++) begin
                if (!kv_written[cache_index(j, kvh, d)] || $urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 7) == 0) send_noise();
                    it.req  = REQ_KV;
                    it.pos  = 8'(j);
                    it.head = 4'(kvh);
                    it.dim  = 6'(d);
                    it.e1   = rand_elem();
                    it.e2   = rand_elem();
                    send_item(it);
                end
            end
        end
        all_seen = 1'b1;
        for (int d = 0; d < hd - 1; d++)
            if (!q_written[d]) all_seen = 1'b0;
        it.req  = REQ_QUERY;
        it.pos  = 8'(p);
        it.head = 4'(qh);
        it.e2   = rand_elem();
        // A stale query resends only its last element once the rest were seen.
        for (int d = (stale && all_seen) ? hd - 1 : 0; d < hd; d++) begin
            if (d < hd - 1 && $urandom_range(0, 7) == 0) send_noise();
            it.dim = 6'(d);
            it.e1  = rand_elem();
            send_item(it);
        end
    endtask

    // Waits until the block is idle, then writes all four registers.
    task automatic write_regs(input int hd, input int nq, input int nkv, input int scale);
        cfg_idx_t idx [4];
        int       val [4];
        idx = '{REG_HEAD_DIM, REG_NUM_Q, REG_NUM_KV, REG_SCALE};
        val = '{hd, nq, nkv, scale};
        drop_valid();
        wait (attn_expect_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        for (int i = 0; i < 4; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i][15:0];
        end
        @(negedge aclk) cfg_wr_en <= 1'b0;
        reg_hd    = hd & 7'h7F;
        reg_nq    = nq & 5'h1F;
        reg_nkv   = nkv & 3'h7;
        reg_scale = scale & 16'hFFFF;
    endtask

    // Result checker with random stalls and one long hold-off.
    initial begin
        attn_out_t exp_r;
        attn_out_t got;
        int        stall;
        m_tready = 1'b0;
        forever begin
            if (hold_request) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_request = 1'b0;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 29) == 0) rx_quiet = ~rx_quiet;
            if (stall > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.head  = m_tdata[3:0];
            got.dim   = m_tdata[9:4];
            got.value = m_tdata[25:10];
            got.last  = m_tlast;
            results_seen++;
            if (attn_expect_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result head=%0d dim=%0d value=%0d last=%0b",
                         $time, got.head, got.dim, got.value, got.last);
            end else begin
                exp_r = attn_expect_q.pop_front();
                if (got.head != exp_r.head) begin
                    error_count++;
                    $display("%0t: out_head expected %0d actual %0d",
                             $time, exp_r.head, got.head);
                end
                if (got.dim != exp_r.dim) begin
                    error_count++;
                    $display("%0t: out_dim expected %0d actual %0d",
                             $time, exp_r.dim, got.dim);
                end
                if (got.value != exp_r.value) begin
                    error_count++;
                    $display("%0t: out_value (head %0d dim %0d) expected %0d actual %0d",
                             $time, exp_r.head, exp_r.dim, exp_r.value, got.value);
                end
                if (got.last != exp_r.last) begin
                    error_count++;
                    $display("%0t: last (dim %0d) expected %0b actual %0b",
                             $time, exp_r.dim, exp_r.last, got.last);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either stream.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d idle cycles, %0d results pending",
                         quiet_cycles, attn_expect_q.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Stimulus: reset, defaults, directed table, random phases, drain.
    initial begin
        directed_row_t rows [$];
        phase_cfg_t    phases [$];
        int            qsize;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = REG_HEAD_DIM;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = REQ_KV;
        error_count  = 0;
        items_sent   = 0;
        queries_done = 0;
        results_seen = 0;
        hold_request = 1'b0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        reg_hd       = 64;
        reg_nq       = 8;
        reg_nkv      = 2;
        reg_scale    = 8192;
        for (int i = 0; i < MAX_POS * MAX_KVH * MAX_DIM; i++) begin
            key_mem[i]    = '0;
            val_mem[i]    = '0;
            kv_written[i] = 1'b0;
        end
        for (int d = 0; d < MAX_DIM; d++) begin
            query_vec[d] = '0;
            q_written[d] = 1'b0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Register defaults after reset, full head dimension.
        attend($urandom_range(0, 7), 0, 1'b0);

        // Directed: one dimension and one kv head per query head, so a
        // single cached position returns its value unchanged.
        write_regs(1, 4, 4, 65535);
        rows = '{
            '{'{REQ_KV,    0,   0, 0, 16'sh7FFF, 16'sh8000}, 1'b0, 0},
            '{'{REQ_QUERY, 0,   0, 0, 16'sh8000, 16'sh7FFF}, 1'b1, 16'sh8000},
            '{'{REQ_KV,    0,   3, 0, 16'sh8000, 16'sh7FFF}, 1'b0, 0},
            '{'{REQ_QUERY, 0,   3, 0, 16'sh7FFF, 16'sh0000}, 1'b1, 16'sh7FFF},
            '{'{REQ_KV,    1,   0, 0, 16'sh8000, 16'sd1234}, 1'b0, 0},
            '{'{REQ_QUERY, 1,   0, 0, 16'sh8000, 16'sh5555}, 1'b0, 0},
            '{'{REQ_KV,    1,   0, 0, 16'sd100,  -16'sd700}, 1'b0, 0},
            '{'{REQ_QUERY, 1,   0, 0, 16'sd300,  16'shAAAA}, 1'b0, 0},
            '{'{REQ_KV,    0,   4, 0, 16'sh1234, 16'sh4321}, 1'b0, 0},
            '{'{REQ_KV,    0,   0, 1, 16'sh1111, 16'sh2222}, 1'b0, 0},
            '{'{REQ_QUERY, 0,   4, 0, 16'sh0F0F, 16'sh0000}, 1'b0, 0},
            '{'{REQ_QUERY, 0,   0, 63, 16'shF0F0, 16'sh0000}, 1'b0, 0},
            '{'{REQ_QUERY, 255, 15, 0, 16'sh7FFF, 16'sh7FFF}, 1'b0, 0},
            '{'{REQ_KV,    255, 2, 0, 16'sh5555, 16'shAAAA}, 1'b0, 0},
            '{'{REQ_KV,    0,   2, 0, 16'sh0000, 16'sh0000}, 1'b0, 0},
            '{'{REQ_QUERY, 0,   2, 0, 16'sh0000, 16'shFFFF}, 1'b1, 16'sh0000},
            '{'{REQ_KV,    0,   1, 0, 16'sd1,    -16'sd1},   1'b0, 0},
            '{'{REQ_QUERY, 0,   1, 0, -16'sd1,   16'sh0000}, 1'b1, -16'sd1}
        };
        foreach (rows[i]) begin
            qsize = attn_expect_q.size();
            send_item(rows[i].item);
            // A hand-computed value replaces the model's for that output.
            if (rows[i].typed && attn_expect_q.size() > qsize)
                attn_expect_q[$].value = rows[i].value;
        end

        // Random phases: clamped extremes, uneven grouping, scale extremes.
        phases = '{
            '{4,   8,  2, 8192,  7,  35},
            '{0,   16, 4, 65535, 40, 35},
            '{127, 1,  1, 0,     0,  20},
            '{3,   5,  3, 23170, 9,  35},
            '{8,   31, 7, 0,     6,  35},
            '{2,   0,  0, 32768, 12, 30}
        };
        foreach (phases[k]) begin
            write_regs(phases[k].hd, phases[k].nq, phases[k].nkv,
                       (k == 4) ? $urandom_range(0, 65535) : phases[k].scale);
            if (k == 0) hold_request = 1'b1;
            phase_items = 0;
            while (phase_items < phases[k].budget)
                attend($urandom_range(0, eff_nq() - 1),
                       $urandom_range(0, phases[k].max_pos),
                       $urandom_range(0, 3) == 0);
        end

        // Drain and settle.
        drop_valid();
        wait (attn_expect_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        $display("Sent %0d transactions over %0d register settings, %0d attention passes,",
                 items_sent, phases.size() + 2, queries_done);
        $display("checked %0d output elements with %0d mismatches.",
                 results_seen, error_count);
        if (error_count == 0 && attn_expect_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
